/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the async reset is active.
`define NPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion checked during reset as well.
`define NPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/nps_pkg.sv */
// Types and constants for the priority scheduler.
// No dependencies; used by nps_cell, nonpreemptive_priority_scheduler and the bench.
`default_nettype none

package nps_pkg;

	// request kinds
	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	// input word
	typedef struct packed {
		logic        req_type;
		logic [7:0]  task_id;
		logic [3:0]  task_priority;
		logic [11:0] burst_length;
	} req_word_t;

	// result word
	typedef struct packed {
		logic        busy_res;
		logic [7:0]  running_id;
		logic        finished;
		logic [15:0] start_time;
		logic [15:0] end_time;
		logic [15:0] turnaround_time;
		logic [15:0] wait_span;
		logic        dropped;
		logic [3:0]  ready_count;
	} rsp_word_t;

	// fixed-width part of one ready-list entry
	typedef struct packed {
		logic [7:0]  id;
		logic [3:0]  prio;
		logic [11:0] burst;
	} entry_key_t;

	// per-cell control from the top level
	typedef struct packed {
		logic ins;   // arrival accepted into the list this cycle
		logic pop;   // head promoted, list shifts toward the head
		logic occ;   // cell holds a live entry
		logic tail;  // cell is the first free slot
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/nonpreemptive_priority_scheduler.sv */
// The result word of an accepted request word is registered and valid in the next cycle.
// Throughput: one word per cycle while each result word is taken; the ready list is a row
// of cells that insert and shift in place; the result register frees as soon as it is taken.
// Reset clears the list count, the running task, the time counter and the result
// register; list entries are not cleared and are read only below the count.
`default_nettype none

`include "assert_macros.svh"

module nonpreemptive_priority_scheduler #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	output logic                  req_ready,
	input  nps_pkg::req_word_t    req,
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	output nps_pkg::rsp_word_t    rsp
);

	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [CW-1:0]        count_q;
	logic                 run_valid_q;
	logic [7:0]           run_id_q;
	logic [11:0]          run_burst_q;
	logic [TIME_BITS-1:0] run_arrival_q;
	logic [11:0]          run_done_q;
	logic [TIME_BITS-1:0] run_start_q;
	logic [TIME_BITS-1:0] cur_time_q;
	logic                 rsp_valid_q;
	nps_pkg::rsp_word_t   rsp_q;

	logic                 accept;
	logic                 is_tick;
	logic                 full;
	logic                 ins;
	logic                 promote;
	logic                 pop;
	nps_pkg::entry_key_t  new_key;

	nps_pkg::entry_key_t  key_w     [MAX_TASKS];
	logic [TIME_BITS-1:0] arrival_w [MAX_TASKS];
	logic                 place_w   [MAX_TASKS];

	// handshake and request decode
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign is_tick   = (req.req_type == nps_pkg::REQ_TICK);
	assign full      = (count_q == CW'(MAX_TASKS));
	assign ins       = accept && !is_tick && !full;
	assign promote   = !run_valid_q && (count_q != '0);
	assign pop       = accept && is_tick && promote;

	// arriving entry; a zero burst runs one tick
	always_comb begin
		new_key.id    = req.task_id;
		new_key.prio  = req.task_priority;
		new_key.burst = (req.burst_length == '0) ? 12'd1 : req.burst_length;
	end

	// row of list cells, head at index 0
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		nps_pkg::cell_ctrl_t  ctl;
		logic                 lp;
		nps_pkg::entry_key_t  lk;
		logic [TIME_BITS-1:0] la;
		nps_pkg::entry_key_t  rk;
		logic [TIME_BITS-1:0] ra;

		always_comb begin
			ctl.ins  = ins;
			ctl.pop  = pop;
			ctl.occ  = (CW'(i) < count_q);
			ctl.tail = (CW'(i) == count_q);
		end

		if (i == 0) begin : g_head
			assign lp = 1'b0;
			assign lk = new_key;
			assign la = cur_time_q;
		end else begin : g_mid
			assign lp = place_w[i-1];
			assign lk = key_w[i-1];
			assign la = arrival_w[i-1];
		end

		if (i == MAX_TASKS - 1) begin : g_last
			assign rk = key_w[i];
			assign ra = arrival_w[i];
		end else begin : g_inner
			assign rk = key_w[i+1];
			assign ra = arrival_w[i+1];
		end

		nps_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.new_key      (new_key),
			.new_arrival  (cur_time_q),
			.left_place   (lp),
			.left_key     (lk),
			.left_arrival (la),
			.right_key    (rk),
			.right_arrival(ra),
			.place        (place_w[i]),
			.key          (key_w[i]),
			.arrival      (arrival_w[i])
		);
	end

	// effective running task for a tick, after a possible promotion
	logic                 eff_valid;
	logic [7:0]           eff_id;
	logic [11:0]          eff_burst;
	logic [TIME_BITS-1:0] eff_arrival;
	logic [TIME_BITS-1:0] eff_start;
	logic [11:0]          done_next;
	logic [TIME_BITS-1:0] time_next;
	logic                 fin;
	logic [TIME_BITS-1:0] turn;
	logic [TIME_BITS-1:0] wait_t;

	always_comb begin
		eff_valid   = run_valid_q || promote;
		eff_id      = promote ? key_w[0].id    : run_id_q;
		eff_burst   = promote ? key_w[0].burst : run_burst_q;
		eff_arrival = promote ? arrival_w[0]   : run_arrival_q;
		eff_start   = promote ? cur_time_q     : run_start_q;
		done_next   = promote ? 12'd1 : (run_done_q + 12'd1);
		time_next   = cur_time_q + TIME_BITS'(1);
		fin         = eff_valid && (done_next >= eff_burst);
		turn        = time_next - eff_arrival;
		wait_t      = turn - TIME_BITS'(eff_burst);
	end

	// list count after this word
	logic [CW-1:0] count_next;
	logic [CW+3:0] count_ext;

	always_comb begin
		count_next = count_q;
		if (ins) begin
			count_next = count_q + CW'(1);
		end else if (pop) begin
			count_next = count_q - CW'(1);
		end
		count_ext = (CW+4)'(count_next);
	end

	// result word
	nps_pkg::rsp_word_t rsp_d;

	always_comb begin
		rsp_d = '0;
		if (is_tick) begin
			rsp_d.busy_res = eff_valid;
			rsp_d.running_id = eff_valid ? eff_id : 8'd0;
			if (fin) begin
				rsp_d.finished        = 1'b1;
				rsp_d.start_time      = 16'(eff_start);
				rsp_d.end_time        = 16'(time_next);
				rsp_d.turnaround_time = 16'(turn);
				rsp_d.wait_span       = 16'(wait_t);
			end
		end else begin
			rsp_d.busy_res   = run_valid_q;
			rsp_d.running_id = run_valid_q ? run_id_q : 8'd0;
			rsp_d.dropped    = full;
		end
		rsp_d.ready_count = (count_ext > (CW+4)'(15)) ? 4'hF : count_ext[3:0];
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			run_valid_q   <= 1'b0;
			run_id_q      <= '0;
			run_burst_q   <= '0;
			run_arrival_q <= '0;
			run_done_q    <= '0;
			run_start_q   <= '0;
			cur_time_q    <= '0;
		end else if (accept) begin
			count_q <= count_next;
			if (is_tick) begin
				cur_time_q  <= time_next;
				run_valid_q <= eff_valid && !fin;
				if (promote) begin
					run_id_q      <= key_w[0].id;
					run_burst_q   <= key_w[0].burst;
					run_arrival_q <= arrival_w[0];
					run_start_q   <= cur_time_q;
				end
				if (eff_valid) begin
					run_done_q <= done_next;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= rsp_d;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`NPS_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || count_q <= CW'(MAX_TASKS), "list count above capacity")
	`NPS_ASSERT(a_drop_when_full, clk, arst_n, accept && !is_tick && full |=> rsp_valid_q && rsp_q.dropped && (count_q == $past(count_q)), "full arrival not dropped")
	`NPS_ASSERT(a_time_advance, clk, arst_n, accept && is_tick |=> cur_time_q == $past(cur_time_q) + TIME_BITS'(1), "time did not advance on tick")
	`NPS_ASSERT(a_fin_busy, clk, arst_n, rsp_valid_q && rsp_q.finished |-> rsp_q.busy_res && !run_valid_q, "finish without a running task")

endmodule

`default_nettype wire

/* hw/rtl/nps_cell.sv */
// One slot of the sorted ready list: holds an entry and trades it with neighbors.
// Depends on nps_pkg.
`default_nettype none

module nps_cell #(
	parameter int TIME_BITS = 16
) (
	input  wire                        clk,
	input  nps_pkg::cell_ctrl_t        ctl,
	input  nps_pkg::entry_key_t        new_key,
	input  wire  [TIME_BITS-1:0]       new_arrival,
	input  wire                        left_place,
	input  nps_pkg::entry_key_t        left_key,
	input  wire  [TIME_BITS-1:0]       left_arrival,
	input  nps_pkg::entry_key_t        right_key,
	input  wire  [TIME_BITS-1:0]       right_arrival,
	output logic                       place,
	output nps_pkg::entry_key_t        key,
	output logic [TIME_BITS-1:0]       arrival
);

	nps_pkg::entry_key_t  key_q;
	logic [TIME_BITS-1:0] arrival_q;
	logic                 take;

	// new word goes ahead of this entry when strictly higher priority
	always_comb begin
		take  = ctl.occ && (key_q.prio < new_key.prio);
		place = take || ctl.tail;
	end

	// insert shifts toward the tail, pop shifts toward the head
	always_ff @(posedge clk) begin
		if (ctl.ins && place) begin
			if (left_place) begin
				key_q     <= left_key;
				arrival_q <= left_arrival;
			end else begin
				key_q     <= new_key;
				arrival_q <= new_arrival;
			end
		end else if (ctl.pop) begin
			key_q     <= right_key;
			arrival_q <= right_arrival;
		end
	end

	assign key     = key_q;
	assign arrival = arrival_q;

endmodule

`default_nettype wire

/* bench/nonpreemptive_priority_scheduler_tb.sv */
// Self-checking bench for the nonpreemptive priority scheduler.
// Needs nps_pkg and the scheduler RTL; a scoreboard class predicts every result word.
`timescale 1ns / 100ps

module nonpreemptive_priority_scheduler_tb;

	localparam int CYCLE_LIMIT  = 60000;
	localparam int STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;

	// Ready list, running task and clock of the scheduler, kept in step with the
	// accepted request words; each word yields one expected result word.
	class sched_scoreboard;
		localparam int LIST_DEPTH = 8;

		logic [7:0]  slot_id      [LIST_DEPTH];
		logic [3:0]  slot_prio    [LIST_DEPTH];
		logic [11:0] slot_burst   [LIST_DEPTH];
		logic [15:0] slot_arrival [LIST_DEPTH];
		int          waiting;
		bit          running;
		logic [7:0]  run_id;
		logic [11:0] run_burst;
		logic [11:0] run_ticks;
		logic [15:0] run_arrival;
		logic [15:0] run_start;
		logic [15:0] now;
		nps_pkg::rsp_word_t awaited [$];
		int          errors;
		int          checked;

		function new();
			waiting     = 0;
			running     = 1'b0;
			run_id      = '0;
			run_burst   = '0;
			run_ticks   = '0;
			run_arrival = '0;
			run_start   = '0;
			now         = '0;
			errors      = 0;
			checked     = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			$display("result %0d: %s is %0h, expected %0h", checked, what, got, want);
			errors++;
		endtask

		// Work out the result word of one accepted request word.
		function void note_request(nps_pkg::req_word_t w);
			nps_pkg::rsp_word_t r;
			int          pos;
			logic [11:0] need;
			logic [15:0] turn;
			r = '0;
			if (w.req_type == nps_pkg::REQ_ARRIVAL) begin
				if (waiting >= LIST_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					// zero burst still runs one tick
					need = (w.burst_length == '0) ? 12'd1 : w.burst_length;
					// behind every entry of equal or higher priority
					pos = 0;
					while (pos < waiting && slot_prio[pos] >= w.task_priority)
						pos++;
					for (int i = waiting; i > pos; i--) begin
						slot_id[i]      = slot_id[i-1];
						slot_prio[i]    = slot_prio[i-1];
						slot_burst[i]   = slot_burst[i-1];
						slot_arrival[i] = slot_arrival[i-1];
					end
					slot_id[pos]      = w.task_id;
					slot_prio[pos]    = w.task_priority;
					slot_burst[pos]   = need;
					slot_arrival[pos] = now;
					waiting++;
				end
				if (running) begin
					r.busy_res   = 1'b1;
					r.running_id = run_id;
				end
			end else begin
				// idle processor takes the head of the list
				if (!running && waiting > 0) begin
					running     = 1'b1;
					run_id      = slot_id[0];
					run_burst   = slot_burst[0];
					run_arrival = slot_arrival[0];
					run_ticks   = '0;
					run_start   = now;
					for (int i = 1; i < waiting; i++) begin
						slot_id[i-1]      = slot_id[i];
						slot_prio[i-1]    = slot_prio[i];
						slot_burst[i-1]   = slot_burst[i];
						slot_arrival[i-1] = slot_arrival[i];
					end
					waiting--;
				end
				now = now + 16'd1;
				if (running) begin
					r.busy_res   = 1'b1;
					r.running_id = run_id;
					run_ticks    = run_ticks + 12'd1;
					if (run_ticks >= run_burst) begin
						turn              = now - run_arrival;
						r.finished        = 1'b1;
						r.start_time      = run_start;
						r.end_time        = now;
						r.turnaround_time = turn;
						r.wait_span       = turn - {4'd0, run_burst};
						running           = 1'b0;
					end
				end
			end
			r.ready_count = 4'(waiting);
			awaited.push_back(r);
		endfunction

		// Compare one delivered result word with the oldest expectation.
		task check_result(nps_pkg::rsp_word_t got);
			nps_pkg::rsp_word_t want;
			if (awaited.size() == 0) begin
				report("unexpected result word", got.running_id, 0);
				return;
			end
			want = awaited.pop_front();
			if (got.busy_res !== want.busy_res)
				report("busy_res", got.busy_res, want.busy_res);
			if (got.running_id !== want.running_id)
				report("running_id", got.running_id, want.running_id);
			if (got.finished !== want.finished)
				report("finished", got.finished, want.finished);
			if (got.start_time !== want.start_time)
				report("start_time", got.start_time, want.start_time);
			if (got.end_time !== want.end_time)
				report("end_time", got.end_time, want.end_time);
			if (got.turnaround_time !== want.turnaround_time)
				report("turnaround_time", got.turnaround_time, want.turnaround_time);
			if (got.wait_span !== want.wait_span)
				report("wait_span", got.wait_span, want.wait_span);
			if (got.dropped !== want.dropped)
				report("dropped", got.dropped, want.dropped);
			if (got.ready_count !== want.ready_count)
				report("ready_count", got.ready_count, want.ready_count);
			checked++;
		endtask

		task flag_leftovers();
			if (awaited.size() != 0)
				report("result words never delivered", 0, awaited.size());
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	nps_pkg::req_word_t req;
	logic               rsp_valid;
	logic               rsp_ready;
	nps_pkg::rsp_word_t rsp;

	sched_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_seq;
	int stall_seen;
	int stall_left;

	nonpreemptive_priority_scheduler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Both handshakes seen at the same edge, request first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (stall_seq != stall_seen) begin
			stall_seen = stall_seq;
			stall_left = STALL_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic nps_pkg::req_word_t make_arrival(logic [7:0] id, logic [3:0] prio,
			logic [11:0] burst);
		nps_pkg::req_word_t w;
		w.req_type      = nps_pkg::REQ_ARRIVAL;
		w.task_id       = id;
		w.task_priority = prio;
		w.burst_length  = burst;
		return w;
	endfunction

	// Tick word; the task fields carry noise the block must ignore.
	function automatic nps_pkg::req_word_t tick_word();
		nps_pkg::req_word_t w;
		w.req_type      = nps_pkg::REQ_TICK;
		w.task_id       = 8'($urandom_range(255));
		w.task_priority = 4'($urandom_range(15));
		w.burst_length  = 12'($urandom_range(4095));
		return w;
	endfunction

	// Mostly short bursts; narrow mode uses few priority levels to force ties.
	function automatic nps_pkg::req_word_t random_request(int arrival_pct, bit narrow);
		nps_pkg::req_word_t w;
		int                 pick;
		w = tick_word();
		if ($urandom_range(99) < arrival_pct) begin
			w.req_type      = nps_pkg::REQ_ARRIVAL;
			w.task_priority = narrow ? 4'($urandom_range(3) * 5) : 4'($urandom_range(15));
			pick = $urandom_range(99);
			if (pick < 72)
				w.burst_length = 12'($urandom_range(6));
			else if (pick < 97)
				w.burst_length = 12'($urandom_range(40));
			else if (pick < 99)
				w.burst_length = 12'($urandom_range(255));
		end
		return w;
	endfunction

	// Offer one word from the falling edge; returns at the edge that takes it.
	task automatic send_word(input nps_pkg::req_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic random_run(input int count);
		int arrival_pct;
		bit narrow;
		arrival_pct = 35;
		narrow      = 1'b0;
		for (int k = 0; k < count; k++) begin
			// the load shifts now and then so the list both fills and drains
			if (k % 40 == 0) begin
				case ($urandom_range(2))
					0:       arrival_pct = 15;
					1:       arrival_pct = 35;
					default: arrival_pct = 60;
				endcase
				narrow = 1'($urandom_range(1));
			end
			send_word(random_request(arrival_pct, narrow));
		end
	endtask

	initial begin
		int saved_pct;
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_ready     = 1'b0;
		// sender idles lightly, receiver heavily
		send_idle_pct = 15;
		recv_idle_pct = 50;
		stall_seq     = 0;
		stall_seen    = 0;
		stall_left    = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: idle tick, extremes, ties, full list, arrival while running
		send_word(tick_word());
		send_word(make_arrival(8'h00, 4'h0, 12'd0));
		send_word(make_arrival(8'hFF, 4'hF, 12'd1));
		send_word(make_arrival(8'h5A, 4'h7, 12'd3));
		send_word(make_arrival(8'hA5, 4'hF, 12'd2));
		send_word(make_arrival(8'h01, 4'h7, 12'd1));
		send_word(make_arrival(8'h02, 4'h0, 12'd2));
		send_word(make_arrival(8'h03, 4'hA, 12'd1));
		send_word(make_arrival(8'h04, 4'h3, 12'd2));
		send_word(make_arrival(8'h05, 4'hF, 12'd1));
		send_word(make_arrival(8'h06, 4'h0, 12'd1));
		repeat (6) send_word(tick_word());
		send_word(make_arrival(8'h07, 4'h5, 12'd2));
		repeat (6) send_word(tick_word());

		random_run(550);

		// and the other way round, with one long receiver hold-off
		send_idle_pct = 50;
		recv_idle_pct = 15;
		random_run(250);
		stall_seq++;
		saved_pct     = send_idle_pct;
		send_idle_pct = 0;
		random_run(40);
		send_idle_pct = saved_pct;
		random_run(260);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_run(400);

		// longest burst at top priority, then tasks queued behind it
		send_word(make_arrival(8'hC3, 4'hF, 12'hFFF));
		send_word(make_arrival(8'h11, 4'h2, 12'd30));
		send_word(make_arrival(8'h22, 4'h9, 12'd60));
		send_word(make_arrival(8'h33, 4'h9, 12'd5));
		random_run(150);

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flag_leftovers();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
